// ----- hdl/vertex_normal_accumulator_defines.svh -----
// Assertion macros shared by the vertex normal accumulator RTL.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef VERTEX_NORMAL_ACCUMULATOR_DEFINES_SVH
`define VERTEX_NORMAL_ACCUMULATOR_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define VNA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define VNA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/vna_pkg.sv -----
// Shared types and constants of the vertex normal accumulator.
// No dependencies; every RTL module imports this package.
`timescale 1ns / 1ps
`default_nettype none
package vna_pkg;

  localparam int IDX_W   = 10;
  localparam int POS_W   = 16;
  localparam int NRM_W   = 20;
  localparam int UNIT_W  = 16;
  localparam int EDGE_W  = 17;
  localparam int PROD_W  = 34;
  localparam int CROSS_W = 35;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_TRI  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Classified operations held in the command queue.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_TRI   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_READZ = 2'd3;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [IDX_W-1:0]        index_a;
    logic [IDX_W-1:0]        index_b;
    logic [IDX_W-1:0]        index_c;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [NRM_W-1:0] init_nx;
    logic signed [NRM_W-1:0] init_ny;
    logic signed [NRM_W-1:0] init_nz;
  } vna_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]        vertex_index;
    logic signed [NRM_W-1:0] sum_nx;
    logic signed [NRM_W-1:0] sum_ny;
    logic signed [NRM_W-1:0] sum_nz;
  } vna_out_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [IDX_W-1:0]        idx_a;
    logic [IDX_W-1:0]        idx_b;
    logic [IDX_W-1:0]        idx_c;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [NRM_W-1:0] nrm_x;
    logic signed [NRM_W-1:0] nrm_y;
    logic signed [NRM_W-1:0] nrm_z;
  } vna_op_t;

  typedef struct packed {
    logic                      start;
    logic signed [CROSS_W-1:0] cx;
    logic signed [CROSS_W-1:0] cy;
    logic signed [CROSS_W-1:0] cz;
  } vna_norm_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [UNIT_W-1:0] nx;
    logic signed [UNIT_W-1:0] ny;
    logic signed [UNIT_W-1:0] nz;
  } vna_norm_rsp_t;

endpackage
`default_nettype wire

// ----- hdl/vna_front.sv -----
// Input side: accepts command words, classifies them and queues them.
// Depends on vna_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "vertex_normal_accumulator_defines.svh"
module vna_front import vna_pkg::*; #(
  parameter int VERTEX_DEPTH = 1024
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  vna_in_t in_data,
  output logic    head_valid,
  output vna_op_t head,
  input  logic    pop
);

  vna_op_t              q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;
  logic                 a_ok, b_ok, c_ok, keep, push, pop_ok;
  vna_op_t              op;

  always_comb begin
    a_ok = 32'(in_data.index_a) < VERTEX_DEPTH;
    b_ok = 32'(in_data.index_b) < VERTEX_DEPTH;
    c_ok = 32'(in_data.index_c) < VERTEX_DEPTH;
    op.kind  = OP_LOAD;
    op.idx_a = in_data.index_a;
    op.idx_b = in_data.index_b;
    op.idx_c = in_data.index_c;
    op.pos_x = in_data.pos_x;
    op.pos_y = in_data.pos_y;
    op.pos_z = in_data.pos_z;
    op.nrm_x = in_data.init_nx;
    op.nrm_y = in_data.init_ny;
    op.nrm_z = in_data.init_nz;
    keep = 1'b0;
    unique case (in_data.cmd)
      CMD_LOAD: begin
        op.kind = OP_LOAD;
        keep    = a_ok;
      end
      CMD_TRI: begin
        op.kind = OP_TRI;
        keep    = a_ok && b_ok && c_ok;
      end
      CMD_READ: begin
        // An out-of-range read still answers, with zero normals.
        op.kind = a_ok ? OP_READ : OP_READZ;
        keep    = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready   = (count_r != Q_CNT_W'(Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = q_r[rd_ptr_r];
  assign push       = in_valid && in_ready && keep;
  assign pop_ok     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + Q_CNT_W'(push) - Q_CNT_W'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= op;
    end
  end

  `VNA_ASSERT_NOW(a_pop_needs_entry, pop, head_valid, "queue popped while empty")
  `VNA_ASSERT_NEXT(a_full_holds, (count_r == Q_CNT_W'(Q_DEPTH)) && !pop_ok, !in_ready, "full queue lost an entry")

endmodule
`default_nettype wire

// ----- hdl/vna_norm.sv -----
// Iterative unit that turns a cross product into a Q1.14 unit normal.
// Depends on vna_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vna_norm import vna_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  vna_norm_req_t req,
  output vna_norm_rsp_t rsp
);

  localparam int MAG_W = CROSS_W;
  localparam int SQ_W  = 31;
  localparam int DIV_W = 46;
  localparam int Q_W   = 15;
  localparam int LEN_W = 32;

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_SHIFT = 3'd1;
  localparam logic [2:0] N_SQ    = 3'd2;
  localparam logic [2:0] N_ROOT  = 3'd3;
  localparam logic [2:0] N_PREP  = 3'd4;
  localparam logic [2:0] N_DIV   = 3'd5;
  localparam logic [2:0] N_DONE  = 3'd6;

  localparam logic [MAG_W-1:0] LO_LIM = MAG_W'(1) << 30;
  localparam logic [MAG_W-1:0] HI_LIM = MAG_W'(1) << 31;

  logic [2:0]       state_r, state_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [MAG_W-1:0] mag_r [3];
  logic [MAG_W-1:0] mag_nxt [3];
  logic [2:0]       neg_r, neg_nxt;
  logic [MAG_W-1:0] m_r, m_nxt;
  logic [61:0]      prod_r, prod_nxt;
  logic [63:0]      sum_r, sum_nxt;
  logic [63:0]      rem_r, rem_nxt, root_r, root_nxt, bit_r, bit_nxt, trial;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [DIV_W-1:0] drem_r [3];
  logic [DIV_W-1:0] drem_nxt [3];
  logic [Q_W-1:0]   quo_r [3];
  logic [Q_W-1:0]   quo_nxt [3];
  logic [SQ_W-1:0]  sq_sel;
  logic [DIV_W-1:0] dvs;
  logic [MAG_W-1:0] in_mag [3];
  logic [MAG_W-1:0] in_max;

  always_comb begin
    in_mag[0] = req.cx[CROSS_W-1] ? MAG_W'(-req.cx) : MAG_W'(req.cx);
    in_mag[1] = req.cy[CROSS_W-1] ? MAG_W'(-req.cy) : MAG_W'(req.cy);
    in_mag[2] = req.cz[CROSS_W-1] ? MAG_W'(-req.cz) : MAG_W'(req.cz);
    in_max = in_mag[0];
    if (in_mag[1] > in_max) in_max = in_mag[1];
    if (in_mag[2] > in_max) in_max = in_mag[2];
    unique case (cnt_r[1:0])
      2'd0:    sq_sel = mag_r[0][SQ_W-1:0];
      2'd1:    sq_sel = mag_r[1][SQ_W-1:0];
      2'd2:    sq_sel = mag_r[2][SQ_W-1:0];
      default: sq_sel = '0;
    endcase
    trial = root_r + bit_r;
    dvs   = DIV_W'(len_r) << cnt_r[3:0];
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    m_nxt     = m_r;
    prod_nxt  = prod_r;
    sum_nxt   = sum_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    bit_nxt   = bit_r;
    len_nxt   = len_r;
    drem_nxt  = drem_r;
    quo_nxt   = quo_r;
    unique case (state_r)
      N_IDLE: begin
        if (req.start) begin
          mag_nxt = in_mag;
          neg_nxt = {req.cz[CROSS_W-1], req.cy[CROSS_W-1], req.cx[CROSS_W-1]};
          m_nxt   = in_max;
          if (in_max == '0) begin
            // Degenerate triangle: the face normal is zero.
            for (int i = 0; i < 3; i++) quo_nxt[i] = '0;
            state_nxt = N_DONE;
          end else begin
            state_nxt = N_SHIFT;
          end
        end
      end
      N_SHIFT: begin
        if (m_r < LO_LIM) begin
          m_nxt = m_r << 1;
          for (int i = 0; i < 3; i++) mag_nxt[i] = mag_r[i] << 1;
        end else if (m_r >= HI_LIM) begin
          m_nxt = m_r >> 1;
          for (int i = 0; i < 3; i++) mag_nxt[i] = mag_r[i] >> 1;
        end else begin
          cnt_nxt   = '0;
          sum_nxt   = '0;
          state_nxt = N_SQ;
        end
      end
      N_SQ: begin
        prod_nxt = sq_sel * sq_sel;
        if (cnt_r != '0) sum_nxt = sum_r + 64'(prod_r);
        if (cnt_r == 5'd3) begin
          rem_nxt   = sum_nxt;
          root_nxt  = '0;
          bit_nxt   = 64'd1 << 62;
          cnt_nxt   = '0;
          state_nxt = N_ROOT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      N_ROOT: begin
        if (rem_r >= trial) begin
          rem_nxt  = rem_r - trial;
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 5'd31) state_nxt = N_PREP;
      end
      N_PREP: begin
        len_nxt = root_r[LEN_W-1:0];
        for (int i = 0; i < 3; i++) begin
          drem_nxt[i] = (DIV_W'(mag_r[i][SQ_W-1:0]) << 14) + DIV_W'(root_r[LEN_W-1:1]);
          quo_nxt[i]  = '0;
        end
        cnt_nxt   = 5'(Q_W - 1);
        state_nxt = N_DIV;
      end
      N_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if (drem_r[i] >= dvs) begin
            drem_nxt[i]             = drem_r[i] - dvs;
            quo_nxt[i][cnt_r[3:0]] = 1'b1;
          end
        end
        if (cnt_r == '0) begin
          state_nxt = N_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      N_DONE: begin
        state_nxt = N_IDLE;
      end
      default: begin
        state_nxt = N_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    m_r    <= m_nxt;
    prod_r <= prod_nxt;
    sum_r  <= sum_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    bit_r  <= bit_nxt;
    len_r  <= len_nxt;
    drem_r <= drem_nxt;
    quo_r  <= quo_nxt;
  end

  always_comb begin
    rsp.done = (state_r == N_DONE);
    rsp.nx = neg_r[0] ? -$signed(UNIT_W'(quo_r[0])) : $signed(UNIT_W'(quo_r[0]));
    rsp.ny = neg_r[1] ? -$signed(UNIT_W'(quo_r[1])) : $signed(UNIT_W'(quo_r[1]));
    rsp.nz = neg_r[2] ? -$signed(UNIT_W'(quo_r[2])) : $signed(UNIT_W'(quo_r[2]));
  end

endmodule
`default_nettype wire

// ----- hdl/vna_back.sv -----
// Execution side: vertex stores, cross product, accumulation and reads.
// Depends on vna_pkg, vna_norm and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "vertex_normal_accumulator_defines.svh"
module vna_back import vna_pkg::*; #(
  parameter int VERTEX_DEPTH = 1024
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     head_valid,
  input  vna_op_t  head,
  output logic     pop,
  output logic     out_valid,
  input  logic     out_ready,
  output vna_out_t out_data
);

  localparam int AW  = $clog2(VERTEX_DEPTH);
  localparam int PW  = 3 * POS_W;
  localparam int NW  = 3 * NRM_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PRD    = 4'd1;
  localparam logic [3:0] S_EDGE   = 4'd2;
  localparam logic [3:0] S_CROSS  = 4'd3;
  localparam logic [3:0] S_NORM   = 4'd4;
  localparam logic [3:0] S_ACC_RD = 4'd5;
  localparam logic [3:0] S_ACC_WR = 4'd6;
  localparam logic [3:0] S_RD_RD  = 4'd7;
  localparam logic [3:0] S_RD_OUT = 4'd8;

  function automatic logic signed [NRM_W-1:0] sat_add(
    input logic signed [NRM_W-1:0]  x,
    input logic signed [UNIT_W-1:0] y
  );
    logic signed [NRM_W:0] s;
    s = (NRM_W+1)'(x) + (NRM_W+1)'(y);
    if (s[NRM_W] != s[NRM_W-1]) begin
      sat_add = s[NRM_W] ? {1'b1, {(NRM_W-1){1'b0}}} : {1'b0, {(NRM_W-1){1'b1}}};
    end else begin
      sat_add = s[NRM_W-1:0];
    end
  endfunction

  logic [PW-1:0] pos_mem [VERTEX_DEPTH];
  logic [NW-1:0] nrm_mem [VERTEX_DEPTH];

  logic [3:0]                 state_r, state_nxt;
  logic [2:0]                 cnt_r, cnt_nxt;
  vna_op_t                    cur_r, cur_nxt;
  logic [PW-1:0]              pa_r, pa_nxt, pb_r, pb_nxt, pc_r, pc_nxt, pos_rd_r;
  logic [NW-1:0]              nrm_rd_r;
  logic signed [EDGE_W-1:0]   e1_r [3];
  logic signed [EDGE_W-1:0]   e2_r [3];
  logic signed [EDGE_W-1:0]   e1_nxt [3];
  logic signed [EDGE_W-1:0]   e2_nxt [3];
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [CROSS_W-1:0]  c_r [3];
  logic signed [CROSS_W-1:0]  c_nxt [3];
  logic                       start_r, start_nxt;
  logic signed [UNIT_W-1:0]   n_r [3];
  logic signed [UNIT_W-1:0]   n_nxt [3];
  logic                       out_valid_r, out_valid_nxt;
  vna_out_t                   out_r, out_nxt;
  logic [AW-1:0]              pos_raddr, nrm_raddr, nrm_waddr;
  logic                       pos_we, nrm_we;
  logic [NW-1:0]              nrm_wdata;
  logic [IDX_W-1:0]           corner;
  logic signed [EDGE_W-1:0]   mul_a, mul_b;
  logic signed [NRM_W-1:0]    old_n [3];
  logic                       is_read;
  vna_norm_req_t              norm_req;
  vna_norm_rsp_t              norm_rsp;

  vna_norm u_norm (
    .clk (clk),
    .rst_n (rst_n),
    .req (norm_req),
    .rsp (norm_rsp)
  );

  assign norm_req.start = start_r;
  assign norm_req.cx    = c_r[0];
  assign norm_req.cy    = c_r[1];
  assign norm_req.cz    = c_r[2];

  assign is_read = (head.kind == OP_READ) || (head.kind == OP_READZ);
  // Every word waits for the idle state; reads also wait for a free result register.
  assign pop     = (state_r == S_IDLE) && head_valid && (!is_read || !out_valid_r);

  always_comb begin
    unique case (cnt_r[1:0])
      2'd0:    corner = cur_r.idx_a;
      2'd1:    corner = cur_r.idx_b;
      default: corner = cur_r.idx_c;
    endcase
    old_n[0] = nrm_rd_r[NW-1 -: NRM_W];
    old_n[1] = nrm_rd_r[NW-NRM_W-1 -: NRM_W];
    old_n[2] = nrm_rd_r[NRM_W-1:0];
    // Cross product term order: yz, zy, zx, xz, xy, yx.
    unique case (cnt_r)
      3'd0:    begin mul_a = e1_r[1]; mul_b = e2_r[2]; end
      3'd1:    begin mul_a = e1_r[2]; mul_b = e2_r[1]; end
      3'd2:    begin mul_a = e1_r[2]; mul_b = e2_r[0]; end
      3'd3:    begin mul_a = e1_r[0]; mul_b = e2_r[2]; end
      3'd4:    begin mul_a = e1_r[0]; mul_b = e2_r[1]; end
      3'd5:    begin mul_a = e1_r[1]; mul_b = e2_r[0]; end
      default: begin mul_a = '0;      mul_b = '0;      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cur_nxt       = cur_r;
    pa_nxt        = pa_r;
    pb_nxt        = pb_r;
    pc_nxt        = pc_r;
    e1_nxt        = e1_r;
    e2_nxt        = e2_r;
    prod_nxt      = prod_r;
    c_nxt         = c_r;
    start_nxt     = 1'b0;
    n_nxt         = n_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    pos_raddr     = AW'(cur_r.idx_a);
    nrm_raddr     = AW'(cur_r.idx_a);
    pos_we        = 1'b0;
    nrm_we        = 1'b0;
    nrm_waddr     = AW'(corner);
    nrm_wdata     = {sat_add(old_n[0], n_r[0]), sat_add(old_n[1], n_r[1]),
                     sat_add(old_n[2], n_r[2])};
    unique case (state_r)
      S_IDLE: begin
        if (pop) begin
          cur_nxt = head;
          cnt_nxt = '0;
          unique case (head.kind)
            OP_LOAD: begin
              pos_we    = 1'b1;
              nrm_we    = 1'b1;
              nrm_waddr = AW'(head.idx_a);
              nrm_wdata = {head.nrm_x, head.nrm_y, head.nrm_z};
            end
            OP_TRI:  state_nxt = S_PRD;
            default: state_nxt = S_RD_RD;
          endcase
        end
      end
      S_PRD: begin
        unique case (cnt_r[1:0])
          2'd0:    pos_raddr = AW'(cur_r.idx_a);
          2'd1:    pos_raddr = AW'(cur_r.idx_b);
          default: pos_raddr = AW'(cur_r.idx_c);
        endcase
        if (cnt_r == 3'd1) pa_nxt = pos_rd_r;
        if (cnt_r == 3'd2) pb_nxt = pos_rd_r;
        if (cnt_r == 3'd3) begin
          pc_nxt    = pos_rd_r;
          state_nxt = S_EDGE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_EDGE: begin
        for (int i = 0; i < 3; i++) begin
          e1_nxt[i] = EDGE_W'($signed(pb_r[PW-1-i*POS_W -: POS_W]))
                    - EDGE_W'($signed(pa_r[PW-1-i*POS_W -: POS_W]));
          e2_nxt[i] = EDGE_W'($signed(pc_r[PW-1-i*POS_W -: POS_W]))
                    - EDGE_W'($signed(pa_r[PW-1-i*POS_W -: POS_W]));
        end
        cnt_nxt   = '0;
        state_nxt = S_CROSS;
      end
      S_CROSS: begin
        // Multiply in step k, fold the product into the component in step k+1.
        prod_nxt = mul_a * mul_b;
        unique case (cnt_r)
          3'd1:    c_nxt[0] = CROSS_W'(prod_r);
          3'd2:    c_nxt[0] = c_r[0] - CROSS_W'(prod_r);
          3'd3:    c_nxt[1] = CROSS_W'(prod_r);
          3'd4:    c_nxt[1] = c_r[1] - CROSS_W'(prod_r);
          3'd5:    c_nxt[2] = CROSS_W'(prod_r);
          3'd6:    c_nxt[2] = c_r[2] - CROSS_W'(prod_r);
          default: c_nxt    = c_r;
        endcase
        if (cnt_r == 3'd6) begin
          start_nxt = 1'b1;
          state_nxt = S_NORM;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_NORM: begin
        if (norm_rsp.done) begin
          n_nxt[0]  = norm_rsp.nx;
          n_nxt[1]  = norm_rsp.ny;
          n_nxt[2]  = norm_rsp.nz;
          cnt_nxt   = '0;
          state_nxt = S_ACC_RD;
        end
      end
      S_ACC_RD: begin
        nrm_raddr = AW'(corner);
        state_nxt = S_ACC_WR;
      end
      S_ACC_WR: begin
        // Corners are read and written one after another, so a repeated
        // corner sees its own earlier update.
        nrm_we = 1'b1;
        if (cnt_r == 3'd2) begin
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_ACC_RD;
        end
      end
      S_RD_RD: begin
        nrm_raddr = AW'(cur_r.idx_a);
        state_nxt = S_RD_OUT;
      end
      S_RD_OUT: begin
        out_nxt.vertex_index = cur_r.idx_a;
        if (cur_r.kind == OP_READZ) begin
          out_nxt.sum_nx = '0;
          out_nxt.sum_ny = '0;
          out_nxt.sum_nz = '0;
        end else begin
          out_nxt.sum_nx = old_n[0];
          out_nxt.sum_ny = old_n[1];
          out_nxt.sum_nz = old_n[2];
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    cur_r  <= cur_nxt;
    pa_r   <= pa_nxt;
    pb_r   <= pb_nxt;
    pc_r   <= pc_nxt;
    e1_r   <= e1_nxt;
    e2_r   <= e2_nxt;
    prod_r <= prod_nxt;
    c_r    <= c_nxt;
    n_r    <= n_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[AW'(head.idx_a)] <= {head.pos_x, head.pos_y, head.pos_z};
    end
    pos_rd_r <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (nrm_we) begin
      nrm_mem[nrm_waddr] <= nrm_wdata;
    end
    nrm_rd_r <= nrm_mem[nrm_raddr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `VNA_ASSERT_NOW(a_norm_done_in_wait, norm_rsp.done, state_r == S_NORM, "normal unit finished outside its wait")
  `VNA_ASSERT_NOW(a_read_slot_free, pop && is_read, !out_valid_r, "read popped over a pending result")
  `VNA_ASSERT_NEXT(a_start_from_cross, start_r, state_r == S_NORM, "normal unit started outside a triangle")

endmodule
`default_nettype wire

// ----- hdl/vertex_normal_accumulator.sv -----
// Top level of the vertex normal accumulator.
// Depends on vna_pkg, vna_front and vna_back.
`timescale 1ns / 1ps
`default_nettype none
// The block holds VERTEX_DEPTH vertices, each with a Q8.8 position and a
// saturating Q5.14 normal. A load word writes one vertex when the execution
// side pops it. A triangle word reads its three corners, forms the edge
// cross product with one shared multiplier, normalizes it to a Q1.14 unit
// normal and adds that to each corner in order. How long it runs is set by
// the normal unit's one-bit-per-cycle shift (up to 30 steps), its 32-step
// square root and its 15-step dividers. When the cross product is zero the
// normal unit answers at once, with no shift, root or divide steps. A read
// word returns the accumulated normal through S_RD_RD, S_RD_OUT and the
// result register, and an out-of-range read returns zeros. Loads and
// triangles with out-of-range indices and unused command codes are dropped on
// entry. A four-entry queue separates the input handshake from execution, and
// a result register separates execution from the output handshake. The vertex
// stores hold no defined value until loaded.
module vertex_normal_accumulator import vna_pkg::*; #(
  parameter int VERTEX_DEPTH = 1024
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  vna_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output vna_out_t out_data
);

  logic    head_valid;
  vna_op_t head;
  logic    pop;

  // Front side: classification and command queue.
  vna_front #(
    .VERTEX_DEPTH (VERTEX_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // Back side: stores, triangle arithmetic and results.
  vna_back #(
    .VERTEX_DEPTH (VERTEX_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for vertex_normal_accumulator: random and directed
// load, triangle and read words, with results checked against a predictor.
// Depends on vna_pkg and the vertex_normal_accumulator RTL.
module tb_top;
  import vna_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Predicts the normal store and queues the read results that must come back.
  class normal_scoreboard;
    int        pos_mem[1024][3];
    int        nrm_mem[1024][3];
    vna_out_t  pending_reads[$];
    int        errors;
    int        checked;

    function new();
      errors  = 0;
      checked = 0;
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // Face normal in Q1.14 from the raw cross product.
    function void face_normal(input longint c[3], output int n[3]);
      longint unsigned mag[3];
      longint unsigned m;
      longint unsigned s;
      longint unsigned len;
      longint unsigned q;
      m = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = (c[i] < 0) ? longint'(-c[i]) : longint'(c[i]);
        if (mag[i] > m) m = mag[i];
      end
      if (m == 0) begin
        n[0] = 0; n[1] = 0; n[2] = 0;
        return;
      end
      while (m < (64'd1 << 30)) begin
        m = m << 1;
        for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
      end
      while (m >= (64'd1 << 31)) begin
        m = m >> 1;
        for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
      end
      for (int i = 0; i < 3; i++) s = s + mag[i] * mag[i];
      len = int_sqrt(s);
      for (int i = 0; i < 3; i++) begin
        q = (mag[i] * 16384 + len / 2) / len;
        n[i] = (c[i] < 0) ? -int'(q) : int'(q);
      end
    endfunction

    function int sat_add(int x, int y);
      longint r;
      r = longint'(x) + longint'(y);
      if (r > 524287) r = 524287;
      if (r < -524288) r = -524288;
      return int'(r);
    endfunction

    function void note_word(vna_in_t w);
      longint e1[3];
      longint e2[3];
      longint c[3];
      int n[3];
      int corner[3];
      vna_out_t r;
      case (w.cmd)
        CMD_LOAD: begin
          pos_mem[w.index_a] = '{int'(w.pos_x), int'(w.pos_y), int'(w.pos_z)};
          nrm_mem[w.index_a] = '{int'(w.init_nx), int'(w.init_ny), int'(w.init_nz)};
        end
        CMD_TRI: begin
          corner = '{int'(w.index_a), int'(w.index_b), int'(w.index_c)};
          for (int i = 0; i < 3; i++) begin
            e1[i] = pos_mem[corner[1]][i] - pos_mem[corner[0]][i];
            e2[i] = pos_mem[corner[2]][i] - pos_mem[corner[0]][i];
          end
          c[0] = e1[1] * e2[2] - e1[2] * e2[1];
          c[1] = e1[2] * e2[0] - e1[0] * e2[2];
          c[2] = e1[0] * e2[1] - e1[1] * e2[0];
          face_normal(c, n);
          // A corner listed twice picks up the face normal twice.
          for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++)
              nrm_mem[corner[k]][i] = sat_add(nrm_mem[corner[k]][i], n[i]);
        end
        CMD_READ: begin
          r.vertex_index = w.index_a;
          r.sum_nx = NRM_W'(nrm_mem[w.index_a][0]);
          r.sum_ny = NRM_W'(nrm_mem[w.index_a][1]);
          r.sum_nz = NRM_W'(nrm_mem[w.index_a][2]);
          pending_reads.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(vna_out_t got);
      vna_out_t want;
      checked++;
      if (pending_reads.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $realtime, got);
        return;
      end
      want = pending_reads.pop_front();
      if (got.vertex_index !== want.vertex_index || got.sum_nx !== want.sum_nx ||
          got.sum_ny !== want.sum_ny || got.sum_nz !== want.sum_nz) begin
        errors++;
        $display("%0t: mismatch expected idx=%0d n=(%0d,%0d,%0d) actual idx=%0d n=(%0d,%0d,%0d)",
                 $realtime, want.vertex_index, want.sum_nx, want.sum_ny, want.sum_nz,
                 got.vertex_index, got.sum_nx, got.sum_ny, got.sum_nz);
      end
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  vna_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  vna_out_t out_data;

  normal_scoreboard sb;
  bit   loaded[1024];
  int   loaded_list[$];
  bit   no_gaps;
  bit   stall_request;
  int   words_sent;
  int   tri_count;

  vertex_normal_accumulator u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one; none while no_gaps is set.
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one word after a random gap and notes it once it is taken.
  // A zero gap keeps valid high, so words go back to back.
  task send_word(vna_in_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(w);
    words_sent++;
    if (w.cmd == CMD_TRI) tri_count++;
  endtask

  task send_load(int idx, int px, int py, int pz, int nx, int ny, int nz);
    vna_in_t w;
    w = '0;
    w.cmd = CMD_LOAD;
    w.index_a = IDX_W'(idx);
    w.index_b = IDX_W'($urandom);
    w.index_c = IDX_W'($urandom);
    w.pos_x = POS_W'(px); w.pos_y = POS_W'(py); w.pos_z = POS_W'(pz);
    w.init_nx = NRM_W'(nx); w.init_ny = NRM_W'(ny); w.init_nz = NRM_W'(nz);
    if (!loaded[idx]) loaded_list.push_back(idx);
    loaded[idx] = 1'b1;
    send_word(w);
  endtask

  // Triangle and read words carry random noise in the fields they ignore.
  task send_cmd(logic [1:0] cmd, int a, int b, int c);
    vna_in_t      w;
    logic [159:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
    w = noise[$bits(vna_in_t)-1:0];
    w.cmd = cmd;
    w.index_a = IDX_W'(a);
    w.index_b = IDX_W'(b);
    w.index_c = IDX_W'(c);
    send_word(w);
  endtask

  function int any_loaded();
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  // The result side: random back-pressure, plus one long hold-off on request
  // so the result register and the command queue fill and in_ready drops.
  initial begin
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (stall_request) begin
        out_ready <= 1'b0;
        repeat (700) @(posedge clk);
        stall_request = 1'b0;
      end else if (no_gaps || $urandom_range(0, 99) < 60) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                             : $urandom_range(1, 3)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  initial begin
    #8ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int r;
    int idx;
    int waited;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    no_gaps = 1'b0;
    stall_request = 1'b0;
    words_sent = 0;
    tri_count = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme positions and normals, saturation in both directions,
    // degenerate and repeated-corner triangles, an unused command, reads.
    send_load(0, 0, 0, 0, 0, 0, 0);
    send_load(1, 32767, 0, 0, 524287, 524287, 524287);
    send_load(2, 0, 32767, 0, -524288, -524288, -524288);
    send_load(3, -32768, -32768, -32768, 0, 0, 0);
    send_load(1023, 32767, -32768, 32767, 1, -1, 0);
    send_load(682, 'h2AAA, -'h2AAB, 'h5555, 'h2AAAA, -'h2AAAB, 'h55555);
    send_cmd(CMD_TRI, 0, 1, 2);
    send_cmd(CMD_TRI, 2, 1, 0);
    send_cmd(CMD_TRI, 0, 0, 1);
    send_cmd(CMD_TRI, 1, 1, 1);
    send_cmd(CMD_TRI, 3, 1, 2);
    send_cmd(CMD_TRI, 1023, 3, 682);
    send_cmd(CMD_TRI, 1023, 1023, 0);
    send_cmd(CMD_UNUSED, 1023, 1023, 1023);
    send_cmd(CMD_READ, 0, 0, 0);
    send_cmd(CMD_READ, 1, 0, 0);
    send_cmd(CMD_READ, 2, 0, 0);
    send_cmd(CMD_READ, 3, 0, 0);
    send_cmd(CMD_READ, 1023, 0, 0);
    send_cmd(CMD_READ, 682, 0, 0);

    // Random: loads cluster on a small pool so normals accumulate and saturate.
    for (int n = 0; n < 1450; n++) begin
      if (n % 300 == 0) no_gaps = ~no_gaps;
      if (n == 400) stall_request = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 5) begin
        send_cmd(CMD_UNUSED, $urandom, $urandom, $urandom);
        n--;
      end else if (r < 25 || loaded_list.size() < 3) begin
        idx = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 31) : $urandom_range(0, 1023);
        if ($urandom_range(0, 3) == 0)
          send_load(idx, $urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200,
                    $urandom_range(0, 400) - 200, $urandom, $urandom, $urandom);
        else
          send_load(idx, $urandom, $urandom, $urandom,
                    $urandom_range(0, 40000) - 20000, $urandom_range(0, 40000) - 20000,
                    $urandom_range(0, 40000) - 20000);
      end else if (r < 68 || n >= 400 && n < 430) begin
        if (n >= 400 && n < 430) send_cmd(CMD_READ, any_loaded(), $urandom, $urandom);
        else send_cmd(CMD_TRI, any_loaded(), any_loaded(), any_loaded());
      end else begin
        send_cmd(CMD_READ, any_loaded(), $urandom, $urandom);
      end
    end
    in_valid <= 1'b0;

    // A triangle still running never returns anything, so also wait out
    // its worst-case latency after the last read has come back.
    waited = 0;
    while (sb.pending_reads.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (150) @(posedge clk);

    $display("Covered %0d words (%0d triangles) and checked %0d read results.",
             words_sent, tri_count, sb.checked);
    $display("Directed extremes, saturation, degenerate faces and a long result stall.");
    if (sb.errors == 0 && sb.pending_reads.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
